// File: hw/rtl/cdt_pkg.sv
package cdt_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned HOST_W  = 63;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned DIVS_W  = 8;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned DEV_W   = 42;
	localparam int unsigned STEP_W  = 32;
	localparam int unsigned OVF_W   = 32;
	localparam int unsigned PHASE_W = 2;

	localparam logic [STEP_W-1:0] DRIFT_STEP_RESET  = 32'd250000;
	localparam logic [9:0]        NS_PER_US         = 10'd1000;
	localparam logic [DIVS_W-1:0] AVERAGE_DIVISOR   = 8'd5;
	localparam logic [CNT_W-1:0]  AVERAGE_COUNT     = 3'd5;
	localparam logic [CNT_W-1:0]  CALIBRATION_START = 3'd7;

	localparam logic CMD_RESTART = 1'b1;

	localparam logic [PHASE_W-1:0] PH_DISCARD = 2'd0;
	localparam logic [PHASE_W-1:0] PH_AVERAGE = 2'd1;
	localparam logic [PHASE_W-1:0] PH_TRACK   = 2'd2;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              sub;
	} alu_req_t;

endpackage

// File: hw/rtl/cdt_div.sv
module cdt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cdt_pkg::div_req_t req,
	output cdt_pkg::div_rsp_t rsp
);
	import cdt_pkg::*;

	localparam int unsigned STEP_CNT_W = $clog2(WORD_W);
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(WORD_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]     dvd_q;
	logic [DIVS_W-1:0]     dvs_q;
	logic [DIVS_W-1:0]     rem_q;
	logic [DIVS_W:0]       rem_sh;
	logic [DIVS_W:0]       rem_dif;
	logic                  ge;

	assign rem_sh  = {rem_q, dvd_q[WORD_W-1]};
	assign rem_dif = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_STEP;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], ge};
			rem_q <= ge ? rem_dif[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// File: hw/rtl/cdt_alu.sv
module cdt_alu (
	input  cdt_pkg::alu_req_t          req,
	output logic [cdt_pkg::WORD_W-1:0] y
);
	import cdt_pkg::*;

	logic [WORD_W-1:0] b_in;

	assign b_in = req.sub ? ~req.b : req.b;
	assign y    = req.a + b_in + {{(WORD_W-1){1'b0}}, req.sub};

endmodule

// File: hw/rtl/device_clock_drift_tracker.sv
// Device clock drift tracker: each clock event item yields one result item. Device time is
// (device_ticks / tick_divisor) * 1000 ns, computed by a 64-step serial divider shared with
// the divide by five of the averaging sum; all 64-bit sums go through one shared adder.
// Restart, discarded and zero-divisor items skip the divider; averaging and tracking items
// run it once, and the divider yields one quotient bit per cycle; the item that closes
// averaging runs the divider twice and takes one more step (ST_NEGQ) when the sum is
// negative. in_ready is low while an item is in work. A finished result waits in the
// output register while the next item is taken. max_drift_step is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, the block itself does not enforce this.
module device_clock_drift_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cdt_pkg::STEP_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [cdt_pkg::HOST_W-1:0]    host_time,
	input  logic [cdt_pkg::TICK_W-1:0]    device_ticks,
	input  logic [cdt_pkg::DIVS_W-1:0]    tick_divisor,
	input  logic [7:0]                    overflow_increment,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cdt_pkg::PHASE_W-1:0]   phase,
	output logic signed [cdt_pkg::WORD_W-1:0] drift_ns,
	output logic signed [cdt_pkg::WORD_W-1:0] host_reference,
	output logic [cdt_pkg::HOST_W-1:0]    device_time_ns,
	output logic [cdt_pkg::OVF_W-1:0]     overflow_total,
	output logic                          divisor_error
);
	import cdt_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DIV    = 4'd1;
	localparam logic [3:0] ST_HREL   = 4'd2;
	localparam logic [3:0] ST_DRIFT  = 4'd3;
	localparam logic [3:0] ST_ACC    = 4'd4;
	localparam logic [3:0] ST_ABS    = 4'd5;
	localparam logic [3:0] ST_AVG    = 4'd6;
	localparam logic [3:0] ST_NEGQ   = 4'd7;
	localparam logic [3:0] ST_REF    = 4'd8;
	localparam logic [3:0] ST_DIFF   = 4'd9;
	localparam logic [3:0] ST_MAG    = 4'd10;
	localparam logic [3:0] ST_CLAMP  = 4'd11;
	localparam logic [3:0] ST_UPD    = 4'd12;
	localparam logic [3:0] ST_FINISH = 4'd13;

	logic [3:0]        state_q;
	logic [STEP_W-1:0] max_step_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] ref_q;
	logic [WORD_W-1:0] est_q;
	logic [DEV_W-1:0]  last_dev_q;
	logic [OVF_W-1:0]  ovf_q;
	logic              err_q;
	logic              neg_q;
	logic              nz_q;
	logic [HOST_W-1:0] host_q;
	logic [7:0]        incr_q;
	logic [DEV_W-1:0]  dev_q;
	logic [WORD_W-1:0] tmp_q;

	logic              in_fire;
	logic              out_load;
	logic              is_event;
	logic              mag_gt;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	alu_req_t          alu_req;
	logic [WORD_W-1:0] alu_y;

	cdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cdt_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	function automatic logic [PHASE_W-1:0] phase_of(input logic [CNT_W-1:0] c);
		if (c > AVERAGE_COUNT) begin
			return PH_DISCARD;
		end else if (c != '0) begin
			return PH_AVERAGE;
		end
		return PH_TRACK;
	endfunction

	assign in_ready = state_q == ST_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == ST_FINISH) && (!out_valid || out_ready);
	assign is_event = (cmd != CMD_RESTART) && (count_q <= AVERAGE_COUNT) &&
		(tick_divisor != '0);
	assign mag_gt   = (tmp_q[WORD_W-1:STEP_W] != '0) || (tmp_q[STEP_W-1:0] > max_step_q);

	always_comb begin
		div_req = '0;
		alu_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				div_req.start    = in_fire && is_event;
				div_req.dividend = {{(WORD_W-TICK_W){1'b0}}, device_ticks};
				div_req.divisor  = tick_divisor;
			end
			ST_HREL: begin
				alu_req.a   = {1'b0, host_q};
				alu_req.b   = ref_q;
				alu_req.sub = 1'b1;
			end
			ST_DRIFT: begin
				alu_req.a   = {{(WORD_W-DEV_W){1'b0}}, dev_q};
				alu_req.b   = tmp_q;
				alu_req.sub = 1'b1;
			end
			ST_ACC: begin
				alu_req.a = est_q;
				alu_req.b = tmp_q;
			end
			ST_ABS: begin
				alu_req.b        = est_q;
				alu_req.sub      = 1'b1;
				div_req.start    = 1'b1;
				div_req.dividend = est_q[WORD_W-1] ? alu_y : est_q;
				div_req.divisor  = AVERAGE_DIVISOR;
			end
			ST_NEGQ, ST_MAG: begin
				alu_req.b   = tmp_q;
				alu_req.sub = 1'b1;
			end
			ST_REF: begin
				alu_req.a   = ref_q;
				alu_req.b   = tmp_q;
				alu_req.sub = 1'b1;
			end
			ST_DIFF: begin
				alu_req.a   = est_q;
				alu_req.b   = tmp_q;
				alu_req.sub = 1'b1;
			end
			ST_UPD: begin
				alu_req.a   = est_q;
				alu_req.b   = tmp_q;
				alu_req.sub = nz_q && !neg_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_step_q <= DRIFT_STEP_RESET;
			count_q    <= CALIBRATION_START;
			ref_q      <= '0;
			est_q      <= '0;
			last_dev_q <= '0;
			ovf_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_step_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (cmd == CMD_RESTART) begin
							count_q <= CALIBRATION_START;
							state_q <= ST_FINISH;
						end else if (count_q > AVERAGE_COUNT) begin
							count_q <= count_q - 1'b1;
							if (count_q == AVERAGE_COUNT + 1'b1) begin
								ref_q <= {1'b0, host_time};
							end
							state_q <= ST_FINISH;
						end else if (tick_divisor == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_HREL;
					end
				end
				ST_HREL: begin
					state_q <= ST_DRIFT;
				end
				ST_DRIFT: begin
					ovf_q   <= ovf_q + {{(OVF_W-8){1'b0}}, incr_q};
					state_q <= (count_q != '0) ? ST_ACC : ST_DIFF;
				end
				ST_ACC: begin
					est_q   <= alu_y;
					count_q <= count_q - 1'b1;
					state_q <= (count_q == 3'd1) ? ST_ABS : ST_FINISH;
				end
				ST_ABS: begin
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					if (div_rsp.done) begin
						state_q <= neg_q ? ST_NEGQ : ST_REF;
					end
				end
				ST_NEGQ: begin
					state_q <= ST_REF;
				end
				ST_REF: begin
					ref_q   <= alu_y;
					est_q   <= '0;
					state_q <= ST_FINISH;
				end
				ST_DIFF: begin
					state_q <= ST_MAG;
				end
				ST_MAG: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					est_q      <= alu_y;
					last_dev_q <= dev_q;
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					host_q <= host_time;
					incr_q <= overflow_increment;
					err_q  <= (cmd != CMD_RESTART) && (count_q <= AVERAGE_COUNT) &&
						(tick_divisor == '0);
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					dev_q <= DEV_W'(div_rsp.quotient[TICK_W-1:0] * NS_PER_US);
				end
			end
			ST_HREL, ST_DRIFT, ST_DIFF, ST_NEGQ: begin
				tmp_q <= alu_y;
			end
			ST_ABS: begin
				neg_q <= est_q[WORD_W-1];
			end
			ST_AVG: begin
				if (div_rsp.done) begin
					tmp_q <= div_rsp.quotient;
				end
			end
			ST_MAG: begin
				neg_q <= tmp_q[WORD_W-1];
				nz_q  <= tmp_q != '0;
				tmp_q <= tmp_q[WORD_W-1] ? alu_y : tmp_q;
			end
			ST_CLAMP: begin
				if (mag_gt) begin
					tmp_q <= {{(WORD_W-STEP_W){1'b0}}, max_step_q};
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			phase          <= phase_of(count_q);
			drift_ns       <= est_q;
			host_reference <= ref_q;
			device_time_ns <= {{(HOST_W-DEV_W){1'b0}}, last_dev_q};
			overflow_total <= ovf_q;
			divisor_error  <= err_q;
		end
	end

`ifndef SYNTH
	a_err_not_discard: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_error |-> phase != PH_DISCARD)
		else $error("divisor error reported while discarding");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_item_multi_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("ready right after an accepted item");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV || state_q == ST_AVG)
		else $error("divider finished outside a wait state");
`endif

endmodule

// File: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdt_pkg::*;

	localparam logic CMD_CLOCK_INFO = ~CMD_RESTART;
	localparam logic [HOST_W-1:0] MAX63 = '1;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam int N_DIRECTED = 25;
	localparam int N_PHASES = 5;
	localparam int PHASE_ITEMS = 225;

	typedef struct packed {
		logic              cmd;
		logic [HOST_W-1:0] host_time;
		logic [TICK_W-1:0] ticks;
		logic [DIVS_W-1:0] divisor;
		logic [7:0]        ovf_inc;
	} clock_event_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [WORD_W-1:0]  drift;
		logic [WORD_W-1:0]  href;
		logic [HOST_W-1:0]  dev_time;
		logic [OVF_W-1:0]   ovf_total;
		logic               div_err;
	} tracker_result_t;

	typedef struct packed {
		clock_event_t    ev;
		logic            known;
		tracker_result_t res;
	} directed_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [STEP_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic [HOST_W-1:0] host_time = '0;
	logic [TICK_W-1:0] device_ticks = '0;
	logic [DIVS_W-1:0] tick_divisor = '0;
	logic [7:0] overflow_increment = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PHASE_W-1:0] phase;
	logic signed [WORD_W-1:0] drift_ns;
	logic signed [WORD_W-1:0] host_reference;
	logic [HOST_W-1:0] device_time_ns;
	logic [OVF_W-1:0] overflow_total;
	logic divisor_error;

	// tracker state as the block should hold it
	logic [CNT_W-1:0]  cal_count = CALIBRATION_START;
	logic [WORD_W-1:0] ref_time = '0;
	logic [WORD_W-1:0] drift_est = '0;
	logic [WORD_W-1:0] last_dev_time = '0;
	logic [OVF_W-1:0]  overflow_acc = '0;
	logic [STEP_W-1:0] step_limit = DRIFT_STEP_RESET;

	tracker_result_t awaited_estimates[$];
	directed_row_t directed_events[N_DIRECTED];
	int fail_count = 0;
	int burst_left = 0;

	device_clock_drift_tracker i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cmd               (cmd),
		.host_time         (host_time),
		.device_ticks      (device_ticks),
		.tick_divisor      (tick_divisor),
		.overflow_increment(overflow_increment),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.phase             (phase),
		.drift_ns          (drift_ns),
		.host_reference    (host_reference),
		.device_time_ns    (device_time_ns),
		.overflow_total    (overflow_total),
		.divisor_error     (divisor_error)
	);

	function automatic tracker_result_t advance_tracker(input clock_event_t ev);
		tracker_result_t res;
		logic [WORD_W-1:0] host_rel, dev_t, new_drift, diff, mag, corr;
		res.div_err = 1'b0;
		if (ev.cmd == CMD_RESTART) begin
			cal_count = CALIBRATION_START;
		end else if (cal_count > AVERAGE_COUNT) begin
			cal_count = cal_count - 1'b1;
			if (cal_count == AVERAGE_COUNT) begin
				ref_time = {1'b0, ev.host_time};
			end
		end else if (ev.divisor == '0) begin
			res.div_err = 1'b1;
		end else begin
			host_rel = {1'b0, ev.host_time} - ref_time;
			dev_t = (64'(ev.ticks) / 64'(ev.divisor)) * 64'(NS_PER_US);
			new_drift = dev_t - host_rel;
			overflow_acc = overflow_acc + 32'(ev.ovf_inc);
			if (cal_count != '0) begin
				cal_count = cal_count - 1'b1;
				drift_est = drift_est + new_drift;
				if (cal_count == '0) begin
					// average of five, rounded toward zero
					drift_est = drift_est[63] ?
						64'd0 - ((64'd0 - drift_est) / 64'(AVERAGE_DIVISOR)) :
						drift_est / 64'(AVERAGE_DIVISOR);
					ref_time = ref_time - drift_est;
					drift_est = '0;
				end
			end else begin
				diff = drift_est - new_drift;
				mag = diff[63] ? 64'd0 - diff : diff;
				corr = (mag > 64'(step_limit)) ? 64'(step_limit) : mag;
				if (diff != '0 && !diff[63]) begin
					drift_est = drift_est - corr;
				end else begin
					drift_est = drift_est + corr;
				end
				last_dev_time = dev_t;
			end
		end
		if (cal_count > AVERAGE_COUNT) begin
			res.phase = PH_DISCARD;
		end else if (cal_count != '0) begin
			res.phase = PH_AVERAGE;
		end else begin
			res.phase = PH_TRACK;
		end
		res.drift = drift_est;
		res.href = ref_time;
		res.dev_time = last_dev_time[HOST_W-1:0];
		res.ovf_total = overflow_acc;
		return res;
	endfunction

	task automatic send_event(input clock_event_t ev, input logic known,
			input tracker_result_t typed_res);
		int gap;
		tracker_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= ev.cmd;
		host_time <= ev.host_time;
		device_ticks <= ev.ticks;
		tick_divisor <= ev.divisor;
		overflow_increment <= ev.ovf_inc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = advance_tracker(ev);
		awaited_estimates.push_back(known ? typed_res : predicted);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		burst_left = 0;
		while (awaited_estimates.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver stalls
	initial begin
		int stall_mode, stall_left;
		stall_mode = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = (stall_mode == 3) ? $urandom_range(1, 30) :
					$urandom_range(10, 200);
			end
			stall_left--;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		tracker_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_estimates.size() == 0) begin
				$display("%0t unexpected result item: phase %0d drift %h", $time, phase,
					drift_ns);
				fail_count++;
			end else begin
				want = awaited_estimates.pop_front();
				check_field("phase", 64'(want.phase), 64'(phase));
				check_field("drift_ns", want.drift, drift_ns);
				check_field("host_reference", want.href, host_reference);
				check_field("device_time_ns", 64'(want.dev_time), 64'(device_time_ns));
				check_field("overflow_total", 64'(want.ovf_total), 64'(overflow_total));
				check_field("divisor_error", 64'(want.div_err), 64'(divisor_error));
			end
		end
	end

	initial begin
		clock_event_t ev;
		logic [WORD_W-1:0] dev_t, host64, noise;
		logic [STEP_W-1:0] step_values[N_PHASES];
		int r, m;

		directed_events = '{
			'{'{CMD_RESTART, 63'd0, 32'd0, 8'd0, 8'd0}, 1'b1,
				'{PH_DISCARD, 64'd0, 64'd0, 63'd0, 32'd0, 1'b0}},
			'{'{CMD_CLOCK_INFO, MAX63, TICK_MAX, 8'd0, 8'd255}, 1'b1,
				'{PH_DISCARD, 64'd0, 64'd0, 63'd0, 32'd0, 1'b0}},
			'{'{CMD_CLOCK_INFO, 63'd1_000_000, 32'd5, 8'd1, 8'd7}, 1'b1,
				'{PH_AVERAGE, 64'd0, 64'd1_000_000, 63'd0, 32'd0, 1'b0}},
			'{'{CMD_CLOCK_INFO, 63'd5, 32'd9, 8'd0, 8'd200}, 1'b1,
				'{PH_AVERAGE, 64'd0, 64'd1_000_000, 63'd0, 32'd0, 1'b1}},
			'{'{CMD_CLOCK_INFO, 63'd2_000_000, 32'd1000, 8'd1, 8'd1}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, MAX63, TICK_MAX, 8'd255, 8'd255}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd0, 32'd0, 8'd1, 8'd128}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd3_000_000, 32'd2_000_500, 8'd1, 8'd0}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd4_000_000, 32'd3_000_000, 8'd3, 8'd64}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd10_000_000, 32'd9_000_000, 8'd1, 8'd3}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd11_000_000, 32'd77, 8'd0, 8'd9}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, MAX63, 32'd0, 8'd255, 8'd0}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd0, TICK_MAX, 8'd1, 8'd255}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd0, TICK_MAX, 8'd1, 8'd255}, 1'b0, '0},
			'{'{CMD_RESTART, MAX63, TICK_MAX, 8'd255, 8'd255}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd0, 32'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'h2AAA_AAAA_AAAA_AAAA, 32'h5555_5555, 8'hAA, 8'h55},
				1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'h5555_5555_5555_5555, 32'hAAAA_AAAA, 8'h55, 8'hAA},
				1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd123, 32'd456, 8'd0, 8'd1}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd7_000_000_000, 32'd7_000_000, 8'd2, 8'd17}, 1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd8_000_000_000, 32'd4_000_000_000, 8'd128, 8'd33},
				1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'h4000_0000_0000_0000, 32'h8000_0000, 8'd1, 8'd99},
				1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd9_000_000_000, 32'd1_000_000, 8'd255, 8'd250},
				1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd9_500_000_000, 32'd123_456_789, 8'd16, 8'd5},
				1'b0, '0},
			'{'{CMD_CLOCK_INFO, 63'd9_600_000_000, 32'd123_556_789, 8'd16, 8'd6},
				1'b0, '0}
		};
		step_values[0] = '0;
		step_values[1] = '1;
		step_values[2] = 32'd1;
		step_values[3] = 32'($urandom_range(2, 5000));
		step_values[4] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_event(directed_events[i].ev, directed_events[i].known,
				directed_events[i].res);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain_reports();
			cfg_we <= 1'b1;
			cfg_wdata <= step_values[p];
			step_limit = step_values[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				ev.cmd = CMD_CLOCK_INFO;
				ev.host_time = 63'({$urandom, $urandom});
				ev.ticks = $urandom;
				ev.divisor = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 4)) :
					8'($urandom_range(1, 255));
				ev.ovf_inc = 8'($urandom);
				r = $urandom_range(0, 99);
				if (r < 3) begin
					ev.cmd = CMD_RESTART;
				end else if (r < 8) begin
					ev.divisor = '0;
				end else begin
					// host time placed around the current estimate for most items, else zero, the maximum or random
					dev_t = (64'(ev.ticks) / 64'(ev.divisor)) * 64'(NS_PER_US);
					host64 = ref_time + dev_t - drift_est;
					m = $urandom_range(0, 99);
					if (m < 50) begin
						noise = 64'($urandom_range(0, 2_000_000)) - 64'd1_000_000;
					end else if (m < 65) begin
						noise = {$urandom, $urandom};
						noise = $signed(noise) >>> 20;
					end else begin
						// exact hit: zero difference
						noise = '0;
					end
					if (m < 80) begin
						ev.host_time = 63'(host64 + noise);
					end else if (m < 85) begin
						ev.host_time = '0;
					end else if (m < 90) begin
						ev.host_time = MAX63;
					end
				end
				send_event(ev, 1'b0, '0);
				if (i < PHASE_ITEMS - 1 && $urandom_range(0, 149) == 0) begin
					drain_reports();
				end
			end
		end

		drain_reports();
		repeat (160) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/cdt_pkg.sv
hw/rtl/cdt_div.sv
hw/rtl/cdt_alu.sv
hw/rtl/device_clock_drift_tracker.sv
test/tb_top.sv
